// ===== rtl/sqi_pkg.sv =====
// Shared types and constants for the shift queue with positional insert.
`default_nettype none

package sqi_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_W    = 32;
	localparam int REQ_W     = 2;
	localparam int POS_W     = 5;
	localparam int CAP_W     = 5;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int CMP_W     = (CNT_W > POS_W) ? ((CNT_W > CAP_W) ? CNT_W : CAP_W)
	                                           : ((POS_W > CAP_W) ? POS_W : CAP_W);
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH   = 2'd0,
		REQ_POP    = 2'd1,
		REQ_PEEK   = 2'd2,
		REQ_INSERT = 2'd3
	} req_t;

	// Broadcast to every cell: what the row does this cycle.
	typedef struct packed {
		logic             pop;      // shift every entry one slot toward the head
		logic             put;      // place the new word, shift later entries back
		logic [CNT_W-1:0] put_pos;  // slot that receives the new word
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/sqi_cell.sv =====
// One queue slot: holds a word and loads from either neighbor or the new word.
`default_nettype none

module sqi_cell (
	input  wire logic                              clk,
	input  wire logic [sqi_pkg::IDX_W-1:0]         idx,
	input  wire sqi_pkg::cell_ctl_t                ctl,
	input  wire logic signed [sqi_pkg::WORD_W-1:0] word,
	input  wire logic signed [sqi_pkg::WORD_W-1:0] prev_q,
	input  wire logic signed [sqi_pkg::WORD_W-1:0] next_q,
	output logic signed [sqi_pkg::WORD_W-1:0]      q
);

	logic [sqi_pkg::CNT_W-1:0] idx_x;

	assign idx_x = sqi_pkg::CNT_W'(idx);

	// Payload only: no reset.
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			q <= next_q;
		end else if (ctl.put) begin
			if (idx_x == ctl.put_pos) begin
				q <= word;
			end else if (idx_x > ctl.put_pos) begin
				q <= prev_q;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/shift_queue_with_insert_top.sv =====
// Top level of the shift queue with positional insert: control, cell row, result buffer.
// A result beat is registered into the output register, or into the skid slot while the output is held.
// Throughput: one request per cycle while in_stall is low; every cell shifts in parallel in that cycle.
// A two-deep result buffer (output register plus skid) lets requests keep flowing
// while a result waits; input stalls only when both are occupied.
// Reset (arst_n low, asynchronous): count clears to zero, capacity_limit returns to 16,
// result buffer empties. Entry words are not cleared; a slot is read only after a write.
`default_nettype none

module shift_queue_with_insert_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_wr_en,
	input  wire logic [sqi_pkg::CAP_W-1:0]         cfg_wr_data,
	// request channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [sqi_pkg::REQ_W-1:0]         req_type,
	input  wire logic signed [sqi_pkg::WORD_W-1:0] value_in,
	input  wire logic [sqi_pkg::POS_W-1:0]         position,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   ok,
	output logic signed [sqi_pkg::WORD_W-1:0]      value_out,
	output logic [sqi_pkg::CNT_W-1:0]              count_out
);

	typedef struct packed {
		logic                              ok;
		logic signed [sqi_pkg::WORD_W-1:0] value;
		logic [sqi_pkg::CNT_W-1:0]         count;
	} res_t;

	logic [sqi_pkg::CAP_W-1:0] cap_q;
	logic [sqi_pkg::CNT_W-1:0] count_q;
	logic [sqi_pkg::CNT_W-1:0] count_nxt;

	logic                      accept;
	logic                      full;
	logic                      empty;
	logic [sqi_pkg::CMP_W-1:0] cnt_x;
	logic [sqi_pkg::CMP_W-1:0] cap_x;
	logic [sqi_pkg::CMP_W-1:0] pos_x;

	sqi_pkg::req_t     req;
	sqi_pkg::cell_ctl_t ctl;
	res_t              res;

	logic signed [sqi_pkg::WORD_W-1:0] cell_q [sqi_pkg::DEPTH];

	res_t out_q;
	res_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic out_take;

	// Request decode: full against the smaller of the limit and the physical depth.
	assign req    = sqi_pkg::req_t'(req_type);
	assign accept = in_valid && !in_stall;
	assign cnt_x  = sqi_pkg::CMP_W'(count_q);
	assign cap_x  = sqi_pkg::CMP_W'(cap_q);
	assign pos_x  = sqi_pkg::CMP_W'(position);
	assign full   = (cnt_x >= cap_x) || (count_q == sqi_pkg::CNT_W'(sqi_pkg::DEPTH));
	assign empty  = (count_q == '0);

	always_comb begin
		ctl         = '0;
		res         = '0;
		count_nxt   = count_q;
		// Insert at or past the tail appends.
		ctl.put_pos = (pos_x < cnt_x) ? pos_x[sqi_pkg::CNT_W-1:0] : count_q;
		unique case (req)
			sqi_pkg::REQ_PUSH: begin
				if (!full) begin
					ctl.put     = 1'b1;
					ctl.put_pos = count_q;
					res.ok      = 1'b1;
					count_nxt   = count_q + sqi_pkg::CNT_W'(1);
				end
			end
			sqi_pkg::REQ_POP: begin
				if (!empty) begin
					ctl.pop   = 1'b1;
					res.ok    = 1'b1;
					res.value = cell_q[0];
					count_nxt = count_q - sqi_pkg::CNT_W'(1);
				end
			end
			sqi_pkg::REQ_PEEK: begin
				if (!empty) begin
					res.ok    = 1'b1;
					res.value = cell_q[0];
				end
			end
			sqi_pkg::REQ_INSERT: begin
				if (!full) begin
					ctl.put   = 1'b1;
					res.ok    = 1'b1;
					count_nxt = count_q + sqi_pkg::CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
		res.count = count_nxt;
		// Gate the row so idle cycles hold every cell.
		if (!accept) begin
			ctl.pop = 1'b0;
			ctl.put = 1'b0;
		end
	end

	// Cell row: each slot sees both neighbors; the head's previous input is the new word, the tail folds back on itself.
	for (genvar g = 0; g < sqi_pkg::DEPTH; g++) begin : g_cell
		logic signed [sqi_pkg::WORD_W-1:0] prev_w;
		logic signed [sqi_pkg::WORD_W-1:0] next_w;

		if (g == 0) begin : g_head
			assign prev_w = value_in;
		end else begin : g_mid_prev
			assign prev_w = cell_q[g-1];
		end

		if (g == sqi_pkg::DEPTH - 1) begin : g_tail
			assign next_w = cell_q[g];
		end else begin : g_mid_next
			assign next_w = cell_q[g+1];
		end

		sqi_cell u_cell (
			.clk    (clk),
			.idx    (sqi_pkg::IDX_W'(g)),
			.ctl    (ctl),
			.word   (value_in),
			.prev_q (prev_w),
			.next_q (next_w),
			.q      (cell_q[g])
		);
	end

	// Count and capacity limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= sqi_pkg::CAP_RESET;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
		end
	end

	// Result buffer: output register plus one skid slot.
	assign out_take = out_valid_q && !out_stall;
	assign in_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				// Input is stalled; drain skid into the output when taken.
				if (out_take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (accept) begin
				if (!out_valid_q || out_take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (!out_valid_q || out_take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = out_q.ok;
	assign value_out = out_q.value;
	assign count_out = out_q.count;

endmodule

`default_nettype wire

// ===== rtl/sqi_chk.sv =====
// Port-level checker for the shift queue top level, bound to it.
`default_nettype none

module sqi_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_stall,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic                              ok,
	input wire logic signed [sqi_pkg::WORD_W-1:0] value_out,
	input wire logic [sqi_pkg::CNT_W-1:0]         count_out
);

	logic                      seen_q;
	logic [sqi_pkg::CNT_W-1:0] last_cnt_q;
	logic                      out_beat;

	assign out_beat = out_valid && !out_stall;

	// Track the count reported by the previous result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_cnt_q <= '0;
		end else if (out_beat) begin
			seen_q     <= 1'b1;
			last_cnt_q <= count_out;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count_out <= sqi_pkg::CNT_W'(sqi_pkg::DEPTH)))
		else $error("count_out beyond depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat && seen_q) |->
			((count_out == last_cnt_q + sqi_pkg::CNT_W'(1)) ||
			 (count_out == last_cnt_q - sqi_pkg::CNT_W'(1)) ||
			 (count_out == last_cnt_q)))
		else $error("count moved by more than one entry");

	a_fail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat && seen_q && !ok) |-> (count_out == last_cnt_q && value_out == '0))
		else $error("failed request changed count or returned a word");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(count_out) && $stable(ok)))
		else $error("stalled result beat changed");

endmodule

bind shift_queue_with_insert_top sqi_chk u_sqi_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.ok        (ok),
	.value_out (value_out),
	.count_out (count_out)
);

`default_nettype wire
